/* hdl/ftpr_pkg.sv */
// Shared types and constants for the frame-time percentile ring.
// Used by ftpr_ctrl, ftpr_lane and frame_time_percentile_ring_unit.
package ftpr_pkg;

  localparam int unsigned TimeW     = 48;
  localparam int unsigned FrameW    = 64;
  localparam int unsigned CountOutW = 8;
  localparam int unsigned PctScale  = 100;
  localparam int unsigned Pct50     = 50;
  localparam int unsigned Pct95     = 95;
  localparam int unsigned Pct99     = 99;

  typedef enum logic {
    ACT_PUSH      = 1'b0,
    ACT_SUMMARIZE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_SUM  = 2'd1,
    OP_CAND = 2'd2,
    OP_CMP  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_SUM_WAIT,
    ST_DIV_INIT,
    ST_DIV,
    ST_CAND,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_CHECK,
    ST_OUT_CPU,
    ST_OUT_GPU
  } state_e;

  typedef struct packed {
    logic start;
    op_e  op;
    logic check;
    logic div_init;
    logic div_step;
  } cmd_t;

endpackage

/* hdl/ftpr_lane.sv */
// Datapath for one series: sample ring, sum and maximum, restoring divider
// for the mean, and rank counting for the percentiles. Depends on ftpr_pkg.
module ftpr_lane #(
  parameter int unsigned RING_DEPTH = 128,
  parameter int unsigned AW = 7,
  parameter int unsigned CW = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ftpr_pkg::cmd_t            cmd_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [ftpr_pkg::TimeW-1:0] wdata_i,
  input  logic [AW-1:0]             raddr_i,
  input  logic [CW-1:0]             n_i,
  output logic [ftpr_pkg::TimeW-1:0] mean_o,
  output logic [ftpr_pkg::TimeW-1:0] p50_o,
  output logic [ftpr_pkg::TimeW-1:0] p95_o,
  output logic [ftpr_pkg::TimeW-1:0] p99_o,
  output logic [ftpr_pkg::TimeW-1:0] max_o
);

  localparam int unsigned TW = ftpr_pkg::TimeW;
  localparam int unsigned SW = TW + CW;
  localparam int unsigned PW = CW + 7;

  logic [TW-1:0] mem [RING_DEPTH];
  logic [TW-1:0] rd_q;
  ftpr_pkg::op_e op_q;

  logic [SW-1:0] sum_q, quo_q;
  logic [CW-1:0] rem_q;
  logic [TW-1:0] max_q, cand_q, p50_q, p95_q, p99_q;
  logic [CW-1:0] less_q, le_q;

  logic [CW:0]   rem_sh;
  logic          fits;
  logic [PW-1:0] less_x, le_x, t50, t95, t99;
  logic          hit50, hit95, hit99;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= ftpr_pkg::OP_NONE;
    end else begin
      op_q <= cmd_i.op;
    end
  end

  // Restoring division of the sum by the sample count, one quotient bit per cycle.
  assign rem_sh = {rem_q, quo_q[SW-1]};
  assign fits   = rem_sh >= {1'b0, n_i};

  // Sorted index idx = ceil(n*p/100)-1 holds the candidate exactly when
  // less*100 < n*p and le*100 >= n*p.
  assign less_x = PW'(less_q) * PW'(ftpr_pkg::PctScale);
  assign le_x   = PW'(le_q) * PW'(ftpr_pkg::PctScale);
  assign t50    = PW'(n_i) * PW'(ftpr_pkg::Pct50);
  assign t95    = PW'(n_i) * PW'(ftpr_pkg::Pct95);
  assign t99    = PW'(n_i) * PW'(ftpr_pkg::Pct99);
  assign hit50  = (less_x < t50) && (le_x >= t50);
  assign hit95  = (less_x < t95) && (le_x >= t95);
  assign hit99  = (less_x < t99) && (le_x >= t99);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      sum_q <= '0;
      max_q <= '0;
      quo_q <= '0;
      p50_q <= '0;
      p95_q <= '0;
      p99_q <= '0;
    end else begin
      case (op_q)
        ftpr_pkg::OP_SUM: begin
          sum_q <= sum_q + SW'(rd_q);
          if (rd_q > max_q) begin
            max_q <= rd_q;
          end
        end
        ftpr_pkg::OP_CAND: begin
          cand_q <= rd_q;
          less_q <= '0;
          le_q   <= '0;
        end
        ftpr_pkg::OP_CMP: begin
          less_q <= less_q + CW'(rd_q < cand_q);
          le_q   <= le_q + CW'(rd_q <= cand_q);
        end
        default: begin
        end
      endcase
      if (cmd_i.div_init) begin
        quo_q <= sum_q;
        rem_q <= '0;
      end else if (cmd_i.div_step) begin
        quo_q <= {quo_q[SW-2:0], fits};
        rem_q <= fits ? CW'(rem_sh - {1'b0, n_i}) : rem_sh[CW-1:0];
      end
      if (cmd_i.check) begin
        if (hit50) p50_q <= cand_q;
        if (hit95) p95_q <= cand_q;
        if (hit99) p99_q <= cand_q;
      end
    end
  end

  assign mean_o = quo_q[TW-1:0];
  assign p50_o  = p50_q;
  assign p95_o  = p95_q;
  assign p99_o  = p99_q;
  assign max_o  = max_q;

endmodule

/* hdl/ftpr_ctrl.sv */
// Controller: push bookkeeping (write position, fill count, frame counter)
// and the summarize sequencer that drives both lanes. Depends on ftpr_pkg.
module ftpr_ctrl #(
  parameter int unsigned RING_DEPTH = 128,
  parameter int unsigned AW = 7,
  parameter int unsigned CW = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        action_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        series_o,
  output ftpr_pkg::cmd_t              cmd_o,
  output logic                        we_o,
  output logic [AW-1:0]               waddr_o,
  output logic [AW-1:0]               raddr_o,
  output logic [CW-1:0]               n_o,
  output logic [ftpr_pkg::FrameW-1:0] frames_o
);

  localparam int unsigned SW = ftpr_pkg::TimeW + CW;
  localparam int unsigned DW = $clog2(SW + 1);

  ftpr_pkg::state_e state_q, state_d;
  logic [AW-1:0] wpos_q, wpos_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [ftpr_pkg::FrameW-1:0] frames_q, frames_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d;
  logic [DW-1:0] dcnt_q, dcnt_d;
  logic [CW-1:0] last_idx;
  logic accept;

  assign last_idx = fill_q - CW'(1);
  assign accept   = in_valid_i && (state_q == ftpr_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ftpr_pkg::ST_IDLE;
      wpos_q   <= '0;
      fill_q   <= '0;
      frames_q <= '0;
      i_q      <= '0;
      j_q      <= '0;
      dcnt_q   <= '0;
    end else begin
      state_q  <= state_d;
      wpos_q   <= wpos_d;
      fill_q   <= fill_d;
      frames_q <= frames_d;
      i_q      <= i_d;
      j_q      <= j_d;
      dcnt_q   <= dcnt_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    wpos_d      = wpos_q;
    fill_d      = fill_q;
    frames_d    = frames_q;
    i_d         = i_q;
    j_d         = j_q;
    dcnt_d      = dcnt_q;
    cmd_o       = '{start: 1'b0, op: ftpr_pkg::OP_NONE, check: 1'b0,
                    div_init: 1'b0, div_step: 1'b0};
    we_o        = 1'b0;
    raddr_o     = j_q[AW-1:0];
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    series_o    = 1'b0;
    case (state_q)
      ftpr_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (accept) begin
          if (action_i == ftpr_pkg::ACT_PUSH) begin
            we_o     = 1'b1;
            wpos_d   = (32'(wpos_q) == RING_DEPTH - 1) ? '0 : wpos_q + AW'(1);
            fill_d   = (32'(fill_q) == RING_DEPTH) ? fill_q : fill_q + CW'(1);
            frames_d = frames_q + ftpr_pkg::FrameW'(1);
          end else begin
            cmd_o.start = 1'b1;
            j_d = '0;
            i_d = '0;
            state_d = (fill_q == '0) ? ftpr_pkg::ST_OUT_CPU : ftpr_pkg::ST_SUM;
          end
        end
      end
      ftpr_pkg::ST_SUM: begin
        cmd_o.op = ftpr_pkg::OP_SUM;
        if (j_q == last_idx) begin
          state_d = ftpr_pkg::ST_SUM_WAIT;
        end else begin
          j_d = j_q + CW'(1);
        end
      end
      ftpr_pkg::ST_SUM_WAIT: begin
        state_d = ftpr_pkg::ST_DIV_INIT;
      end
      ftpr_pkg::ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        dcnt_d  = '0;
        state_d = ftpr_pkg::ST_DIV;
      end
      ftpr_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        dcnt_d = dcnt_q + DW'(1);
        if (32'(dcnt_q) == SW - 1) begin
          state_d = ftpr_pkg::ST_CAND;
        end
      end
      ftpr_pkg::ST_CAND: begin
        cmd_o.op = ftpr_pkg::OP_CAND;
        raddr_o  = i_q[AW-1:0];
        j_d      = '0;
        state_d  = ftpr_pkg::ST_SCAN;
      end
      ftpr_pkg::ST_SCAN: begin
        cmd_o.op = ftpr_pkg::OP_CMP;
        if (j_q == last_idx) begin
          state_d = ftpr_pkg::ST_SCAN_WAIT;
        end else begin
          j_d = j_q + CW'(1);
        end
      end
      ftpr_pkg::ST_SCAN_WAIT: begin
        state_d = ftpr_pkg::ST_CHECK;
      end
      ftpr_pkg::ST_CHECK: begin
        cmd_o.check = 1'b1;
        if (i_q == last_idx) begin
          state_d = ftpr_pkg::ST_OUT_CPU;
        end else begin
          i_d = i_q + CW'(1);
          state_d = ftpr_pkg::ST_CAND;
        end
      end
      ftpr_pkg::ST_OUT_CPU: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = ftpr_pkg::ST_OUT_GPU;
        end
      end
      ftpr_pkg::ST_OUT_GPU: begin
        out_valid_o = 1'b1;
        series_o    = 1'b1;
        if (!out_stall_i) begin
          state_d = ftpr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ftpr_pkg::ST_IDLE;
      end
    endcase
  end

  assign waddr_o  = wpos_q;
  assign n_o      = fill_q;
  assign frames_o = frames_q;

endmodule

/* hdl/frame_time_percentile_ring_unit.sv */
// The time of a summarize over n stored samples is set by the rank count: every
// sample is compared with every sample through one memory read port per series,
// and a bit-serial divider forms the mean one quotient bit per cycle over the
// bits of the sum (56 bits at the default depth). Both series are worked in
// parallel and then given CPU first, GPU second with last set.
module frame_time_percentile_ring_unit #(
  parameter int unsigned RING_DEPTH = 128
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        action_i,
  input  logic [ftpr_pkg::TimeW-1:0]  cpu_time_i,
  input  logic [ftpr_pkg::TimeW-1:0]  gpu_time_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        series_o,
  output logic [ftpr_pkg::TimeW-1:0]  mean_time_o,
  output logic [ftpr_pkg::TimeW-1:0]  median_time_o,
  output logic [ftpr_pkg::TimeW-1:0]  p95_time_o,
  output logic [ftpr_pkg::TimeW-1:0]  p99_time_o,
  output logic [ftpr_pkg::TimeW-1:0]  max_time_o,
  output logic [ftpr_pkg::CountOutW-1:0] sample_count_o,
  output logic [ftpr_pkg::FrameW-1:0] frames_seen_o,
  output logic                        last_o
);

  localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned TW = ftpr_pkg::TimeW;

  ftpr_pkg::cmd_t cmd;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [CW-1:0] n;
  logic [TW-1:0] c_mean, c_p50, c_p95, c_p99, c_max;
  logic [TW-1:0] g_mean, g_p50, g_p95, g_p99, g_max;

  ftpr_ctrl #(.RING_DEPTH(RING_DEPTH), .AW(AW), .CW(CW)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i,
    .out_valid_o, .out_stall_i, .series_o,
    .cmd_o(cmd), .we_o(we), .waddr_o(waddr), .raddr_o(raddr), .n_o(n),
    .frames_o(frames_seen_o)
  );

  ftpr_lane #(.RING_DEPTH(RING_DEPTH), .AW(AW), .CW(CW)) u_cpu (
    .clk_i, .rst_ni, .cmd_i(cmd), .we_i(we), .waddr_i(waddr),
    .wdata_i(cpu_time_i), .raddr_i(raddr), .n_i(n),
    .mean_o(c_mean), .p50_o(c_p50), .p95_o(c_p95), .p99_o(c_p99), .max_o(c_max)
  );

  ftpr_lane #(.RING_DEPTH(RING_DEPTH), .AW(AW), .CW(CW)) u_gpu (
    .clk_i, .rst_ni, .cmd_i(cmd), .we_i(we), .waddr_i(waddr),
    .wdata_i(gpu_time_i), .raddr_i(raddr), .n_i(n),
    .mean_o(g_mean), .p50_o(g_p50), .p95_o(g_p95), .p99_o(g_p99), .max_o(g_max)
  );

  assign mean_time_o    = series_o ? g_mean : c_mean;
  assign median_time_o  = series_o ? g_p50 : c_p50;
  assign p95_time_o     = series_o ? g_p95 : c_p95;
  assign p99_time_o     = series_o ? g_p99 : c_p99;
  assign max_time_o     = series_o ? g_max : c_max;
  assign sample_count_o = ftpr_pkg::CountOutW'(n);
  assign last_o         = series_o;

endmodule

/* verif/tb_frame_time_percentile_ring_unit.sv */
// Testbench for frame_time_percentile_ring_unit: directed table, then random pushes and
// summaries checked against a behavioral predictor. Depends on ftpr_pkg and the unit RTL.
`timescale 1ns / 1ps
module tb_frame_time_percentile_ring_unit;

  localparam int unsigned TimeW = ftpr_pkg::TimeW;
  localparam int unsigned FrameW = ftpr_pkg::FrameW;
  localparam int unsigned CountOutW = ftpr_pkg::CountOutW;
  localparam int unsigned Depth = 128;
  localparam int unsigned RandItems = 1100;
  localparam int unsigned StallLimit = 200000;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  typedef struct packed {
    logic               series;
    logic [TimeW-1:0]   mean_t;
    logic [TimeW-1:0]   p50_t;
    logic [TimeW-1:0]   p95_t;
    logic [TimeW-1:0]   p99_t;
    logic [TimeW-1:0]   max_t;
    logic [CountOutW-1:0] count;
    logic [FrameW-1:0]  frames;
    logic               last;
  } stats_t;

  typedef struct {
    ftpr_pkg::action_e act;
    logic [TimeW-1:0]  cpu;
    logic [TimeW-1:0]  gpu;
    bit                typed;  // expected result written out in the row
    logic [FrameW-1:0] frames;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall_o;
  ftpr_pkg::action_e action = ftpr_pkg::ACT_PUSH;
  logic [TimeW-1:0] cpu_time = '0;
  logic [TimeW-1:0] gpu_time = '0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  logic series_o, last_o;
  logic [TimeW-1:0] mean_time_o, median_time_o, p95_time_o, p99_time_o, max_time_o;
  logic [CountOutW-1:0] sample_count_o;
  logic [FrameW-1:0] frames_seen_o;

  frame_time_percentile_ring_unit #(.RING_DEPTH(Depth)) dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o,
    .action_i(action), .cpu_time_i(cpu_time), .gpu_time_i(gpu_time),
    .out_valid_o, .out_stall_i(out_stall),
    .series_o, .mean_time_o, .median_time_o, .p95_time_o, .p99_time_o,
    .max_time_o, .sample_count_o, .frames_seen_o, .last_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state.
  logic [TimeW-1:0] cpu_hist [Depth];
  logic [TimeW-1:0] gpu_hist [Depth];
  int unsigned      wr_pos = 0;
  int unsigned      filled = 0;
  logic [FrameW-1:0] pushes = '0;
  stats_t           pending_stats [$];

  int unsigned errors = 0;
  bit          calm_tail = 1'b0;
  int unsigned quiet_cycles = 0;

  function automatic logic [TimeW-1:0] rank_of(ref logic [TimeW-1:0] s [Depth],
                                               input int unsigned n, input int unsigned pct);
    int unsigned idx;
    idx = (n * pct + ftpr_pkg::PctScale - 1) / ftpr_pkg::PctScale - 1;
    if (idx >= n) idx = n - 1;
    return s[idx];
  endfunction

  function automatic stats_t series_stats(ref logic [TimeW-1:0] hist [Depth],
                                          input logic ser);
    logic [TimeW-1:0] sorted [Depth];
    logic [TimeW-1:0] v;
    logic [63:0] total;
    int j;
    stats_t r;
    r = '0;
    r.series = ser;
    r.last = ser;
    r.frames = pushes;
    r.count = filled[CountOutW-1:0];
    if (filled != 0) begin
      total = '0;
      for (int i = 0; i < filled; i++) begin
        v = hist[i];
        total += 64'(v);
        j = i;
        while (j > 0 && sorted[j-1] > v) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = v;
      end
      r.mean_t = TimeW'(total / filled);
      r.p50_t = rank_of(sorted, filled, ftpr_pkg::Pct50);
      r.p95_t = rank_of(sorted, filled, ftpr_pkg::Pct95);
      r.p99_t = rank_of(sorted, filled, ftpr_pkg::Pct99);
      r.max_t = sorted[filled-1];
    end
    return r;
  endfunction

  task automatic account_transfer(input row_t r);
    stats_t z;
    if (r.act == ftpr_pkg::ACT_PUSH) begin
      cpu_hist[wr_pos] = r.cpu;
      gpu_hist[wr_pos] = r.gpu;
      wr_pos = (wr_pos + 1) % Depth;
      if (filled < Depth) filled++;
      pushes++;
    end else if (r.typed) begin
      z = '0;
      z.frames = r.frames;
      pending_stats.push_back(z);
      z.series = 1'b1;
      z.last = 1'b1;
      pending_stats.push_back(z);
    end else begin
      pending_stats.push_back(series_stats(cpu_hist, 1'b0));
      pending_stats.push_back(series_stats(gpu_hist, 1'b1));
    end
  endtask

  task automatic send(input row_t r);
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    action <= r.act;
    cpu_time <= r.cpu;
    gpu_time <= r.gpu;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    account_transfer(r);
  endtask

  function automatic logic [TimeW-1:0] rand_time();
    case ($urandom_range(0, 3))
      0: return TimeW'($urandom_range(0, 20));
      1: return TimeW'($urandom_range(1000000, 50000000));
      default: return TimeW'({$urandom(), $urandom()});
    endcase
  endfunction

  function automatic row_t push_row(input logic [TimeW-1:0] c, input logic [TimeW-1:0] g);
    row_t r;
    r.act = ftpr_pkg::ACT_PUSH;
    r.cpu = c;
    r.gpu = g;
    r.typed = 1'b0;
    r.frames = '0;
    return r;
  endfunction

  // Receiver stalls in random bursts, none during the tail of the run.
  initial begin
    forever begin
      @(posedge clk_i);
      if (!calm_tail && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [FrameW-1:0] e,
                             input logic [FrameW-1:0] a);
    if (e !== a) begin
      errors++;
      if (errors <= 10) $display("mismatch %s: expected %h, got %h", name, e, a);
    end
  endtask

  always @(posedge clk_i) begin
    stats_t e;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (pending_stats.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result transfer with nothing outstanding");
      end else begin
        e = pending_stats.pop_front();
        check_field("series", FrameW'(e.series), FrameW'(series_o));
        check_field("mean_time", FrameW'(e.mean_t), FrameW'(mean_time_o));
        check_field("median_time", FrameW'(e.p50_t), FrameW'(median_time_o));
        check_field("p95_time", FrameW'(e.p95_t), FrameW'(p95_time_o));
        check_field("p99_time", FrameW'(e.p99_t), FrameW'(p99_time_o));
        check_field("max_time", FrameW'(e.max_t), FrameW'(max_time_o));
        check_field("sample_count", FrameW'(e.count), FrameW'(sample_count_o));
        check_field("frames_seen", e.frames, frames_seen_o);
        check_field("last", FrameW'(e.last), FrameW'(last_o));
      end
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    row_t table_rows [$];
    row_t r;
    // Empty ring first: both results all zero with no frames seen.
    r = push_row('0, '0);
    r.act = ftpr_pkg::ACT_SUMMARIZE;
    r.typed = 1'b1;
    table_rows.push_back(r);
    table_rows.push_back(push_row('0, TimeMax));
    r.typed = 1'b0;
    table_rows.push_back(r);
    table_rows.push_back(push_row(TimeMax, '0));
    table_rows.push_back(r);
    table_rows.push_back(push_row(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA));
    table_rows.push_back(push_row(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555));
    table_rows.push_back(push_row(48'd7, 48'd7));
    table_rows.push_back(r);
    for (int i = 0; i < 10; i++) begin
      table_rows.push_back(push_row(TimeW'(i * 3), TimeMax - TimeW'(i)));
    end
    table_rows.push_back(r);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[i]) send(table_rows[i]);

    // Random part: summaries are frequent while the ring fills and rare once it is
    // full, since a full-ring summary runs the longest rank count.
    for (int unsigned n = 0; n < RandItems; n++) begin
      if (n + 100 >= RandItems) calm_tail = 1'b1;
      r = push_row(rand_time(), rand_time());
      if ((filled < Depth && $urandom_range(0, 4) == 0) ||
          (filled == Depth && $urandom_range(0, 39) == 0) || n + 1 == RandItems)
        r.act = ftpr_pkg::ACT_SUMMARIZE;
      send(r);
    end
    in_valid <= 1'b0;

    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
